/* src/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released
`define TFN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included
`define TFN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* src/tfn_pkg.sv */
// Shared constants for the triangle face normal unit
package tfn_pkg;

  localparam int DEF_COORD_WIDTH = 18;
  localparam int DEF_INDEX_WIDTH = 16;
  // magnitudes are scaled so the largest has this many bits
  localparam int NORM_BITS       = 30;
  // quotient bits of the normal magnitude (0..16384)
  localparam int QUO_W           = 15;
  localparam int Q_ONE           = 16384;
  localparam int NORMAL_W        = 16;
  localparam int FIFO_DEPTH      = 4;

endpackage

/* src/tfn_front.sv */
// Front end: triangle mode register, drop filter and item queue
module tfn_front import tfn_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
  localparam int ItemW = 3 * INDEX_WIDTH + 9 * COORD_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_we_i,
  input  logic             mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ItemW-1:0] in_item_i,
  input  logic             pop_i,
  output logic             item_valid_o,
  output logic [ItemW-1:0] item_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);

  logic             mode_q;
  logic [ItemW-1:0] mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push, pop;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (mode_we_i) begin
      mode_q <= mode_i;
    end
  end

  assign in_ready_o   = (cnt_q != (PtrW+1)'(FIFO_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push         = in_valid_i && in_ready_o && mode_q;
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/tfn_isqrt.sv */
// Pipelined integer square root, one result bit per stage
module tfn_isqrt #(
  parameter int SQ_W   = 62,
  parameter int SIDE_W = 8,
  localparam int RootW = SQ_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RootW-1:0]  root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RemW = RootW + 3;

  logic              vld_q  [RootW];
  logic [RemW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [SQ_W-1:0]   sq_q   [RootW];
  logic [SIDE_W-1:0] side_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic              vin;
    logic [RemW-1:0]   rin;
    logic [RootW-1:0]  oin;
    logic [SQ_W-1:0]   qin;
    logic [SIDE_W-1:0] sin;
    logic [RemW-1:0]   cur, trial;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign oin = '0;
      assign qin = sq_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[s-1];
      assign rin = rem_q[s-1];
      assign oin = root_q[s-1];
      assign qin = sq_q[s-1];
      assign sin = side_q[s-1];
    end

    // bring down the next two bits and try the next root bit
    assign cur   = {rin[RemW-3:0], qin[SQ_W-1-2*s -: 2]};
    assign trial = {1'b0, oin, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qin_copy: begin
          sq_q[s]   <= qin;
          side_q[s] <= sin;
          if (cur >= trial) begin
            rem_q[s]  <= cur - trial;
            root_q[s] <= {oin[RootW-2:0], 1'b1};
          end else begin
            rem_q[s]  <= cur;
            root_q[s] <= {oin[RootW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

/* src/tfn_div.sv */
// Pipelined restoring divider for three numerators over one divisor
module tfn_div #(
  parameter int NUM_W  = 46,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 15,
  parameter int SIDE_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2:0][NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [2:0][Q_W-1:0]     quo_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int XW = DEN_W + Q_W;

  logic                  vld_q  [Q_W];
  logic [2:0][XW-1:0]    rem_q  [Q_W];
  logic [2:0][Q_W-1:0]   quo_q  [Q_W];
  logic [DEN_W-1:0]      den_q  [Q_W];
  logic [SIDE_W-1:0]     side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic                vin;
    logic [2:0][XW-1:0]  rin;
    logic [2:0][Q_W-1:0] qin;
    logic [DEN_W-1:0]    din;
    logic [SIDE_W-1:0]   sin;
    logic [XW-1:0]       sub;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      for (genvar l = 0; l < 3; l++) begin : g_ext
        assign rin[l] = XW'(num_i[l]);
      end
      assign qin = '0;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[s-1];
      assign rin = rem_q[s-1];
      assign qin = quo_q[s-1];
      assign din = den_q[s-1];
      assign sin = side_q[s-1];
    end

    // divisor aligned to quotient bit Q_W-1-s
    assign sub = XW'(din) << (Q_W - 1 - s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= din;
        side_q[s] <= sin;
        for (int l = 0; l < 3; l++) begin
          if (rin[l] >= sub) begin
            rem_q[s][l] <= rin[l] - sub;
            quo_q[s][l] <= qin[l] | (Q_W'(1) << (Q_W - 1 - s));
          end else begin
            rem_q[s][l] <= rin[l];
            quo_q[s][l] <= qin[l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

/* src/tfn_back.sv */
// Back end: cross product, scaling, root, division and output register
module tfn_back import tfn_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
  localparam int ItemW = 3 * INDEX_WIDTH + 9 * COORD_WIDTH,
  localparam int IdxW  = 3 * INDEX_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  logic [ItemW-1:0]          item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IdxW-1:0]           out_idx_o,
  output logic [2:0][NORMAL_W-1:0]  out_normal_o,
  output logic                      out_degenerate_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW;
  localparam int KW    = PW + 1;
  localparam int LW    = $clog2(KW + 1);
  localparam int SqW   = 2 * NORM_BITS + 2;
  localparam int RootW = SqW / 2;
  localparam int DenW  = RootW + 1;
  localparam int NumW  = NORM_BITS + QUO_W + 1;
  localparam int SideS = IdxW + 4 + 3 * NORM_BITS;
  localparam int SideD = IdxW + 4;

  logic en;

  // stage 1: edges
  logic                        v1_q;
  logic [IdxW-1:0]             idx1_q;
  logic signed [2:0][EW-1:0]   e1_q, e2_q;
  // stage 2: products
  logic                        v2_q;
  logic [IdxW-1:0]             idx2_q;
  logic signed [5:0][PW-1:0]   p_q;
  // stage 3: cross terms
  logic                        v3_q;
  logic [IdxW-1:0]             idx3_q;
  logic signed [2:0][KW-1:0]   k_q;
  // stage 4: sign and magnitude
  logic                        v4_q;
  logic [IdxW-1:0]             idx4_q;
  logic [2:0][KW-1:0]          mag4_q;
  logic [2:0]                  neg4_q;
  logic [KW-1:0]               orv_q;
  // stage 5: bit length
  logic                        v5_q;
  logic [IdxW-1:0]             idx5_q;
  logic [2:0][KW-1:0]          mag5_q;
  logic [2:0]                  neg5_q;
  logic                        deg5_q;
  logic [LW-1:0]               len_q, len_d;
  // stage 6: scaled magnitudes
  logic                        v6_q;
  logic [IdxW-1:0]             idx6_q;
  logic [2:0][NORM_BITS-1:0]   m6_q;
  logic [2:0]                  neg6_q;
  logic                        deg6_q;
  // stage 7: squares
  logic                        v7_q;
  logic [IdxW-1:0]             idx7_q;
  logic [2:0][NORM_BITS-1:0]   m7_q;
  logic [2:0]                  neg7_q;
  logic                        deg7_q;
  logic [2:0][2*NORM_BITS-1:0] sq7_q;
  // stage 8: sum of squares
  logic                        v8_q;
  logic [SqW-1:0]              sum8_q;
  logic [SideS-1:0]            side8_q;
  // root
  logic                        vr;
  logic [RootW-1:0]            root;
  logic [SideS-1:0]            sider;
  logic [IdxW-1:0]             idxr;
  logic [2:0][NORM_BITS-1:0]   mr;
  logic [2:0]                  negr;
  logic                        degr;
  // division operands
  logic                        v9_q;
  logic [2:0][NumW-1:0]        num9_q;
  logic [DenW-1:0]             den9_q;
  logic [SideD-1:0]            side9_q;
  // quotients
  logic                        vq;
  logic [2:0][QUO_W-1:0]       quo;
  logic [SideD-1:0]            sideq;
  // output register
  logic                        out_valid_q;
  logic [IdxW-1:0]             out_idx_q;
  logic [2:0][NORMAL_W-1:0]    out_normal_q, normal_d;
  logic                        out_deg_q;

  // the whole pipe moves unless the output register holds a stalled result
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && item_valid_i;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= vr;
      out_valid_q <= vq;
    end
  end

  // leading one of the OR of magnitudes
  always_comb begin
    len_d = '0;
    for (int i = 0; i < KW; i++) begin
      if (orv_q[i]) begin
        len_d = LW'(i + 1);
      end
    end
  end

  // normal magnitude, clamp and sign
  always_comb begin
    logic [QUO_W-1:0] n;
    for (int l = 0; l < 3; l++) begin
      n = (quo[l] > QUO_W'(Q_ONE)) ? QUO_W'(Q_ONE) : quo[l];
      if (sideq[0]) begin
        normal_d[l] = '0;
      end else if (sideq[1+l]) begin
        normal_d[l] = NORMAL_W'(n);
      end else begin
        normal_d[l] = NORMAL_W'(0) - NORMAL_W'(n);
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // edges b-a and c-b
      idx1_q <= item_i[IdxW-1:0];
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= {item_i[IdxW+(3+i)*CW+CW-1], item_i[IdxW+(3+i)*CW +: CW]}
                 - {item_i[IdxW+i*CW+CW-1], item_i[IdxW+i*CW +: CW]};
        e2_q[i] <= {item_i[IdxW+(6+i)*CW+CW-1], item_i[IdxW+(6+i)*CW +: CW]}
                 - {item_i[IdxW+(3+i)*CW+CW-1], item_i[IdxW+(3+i)*CW +: CW]};
      end
      // products
      idx2_q <= idx1_q;
      p_q[0] <= PW'($signed(e1_q[1]) * $signed(e2_q[2]));
      p_q[1] <= PW'($signed(e1_q[2]) * $signed(e2_q[1]));
      p_q[2] <= PW'($signed(e1_q[2]) * $signed(e2_q[0]));
      p_q[3] <= PW'($signed(e1_q[0]) * $signed(e2_q[2]));
      p_q[4] <= PW'($signed(e1_q[0]) * $signed(e2_q[1]));
      p_q[5] <= PW'($signed(e1_q[1]) * $signed(e2_q[0]));
      // cross terms
      idx3_q <= idx2_q;
      for (int i = 0; i < 3; i++) begin
        k_q[i] <= {p_q[2*i][PW-1], p_q[2*i]} - {p_q[2*i+1][PW-1], p_q[2*i+1]};
      end
      // sign and magnitude
      idx4_q <= idx3_q;
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= k_q[i][KW-1];
        mag4_q[i] <= k_q[i][KW-1] ? (KW'(0) - k_q[i]) : k_q[i];
      end
      orv_q <= (k_q[0][KW-1] ? (KW'(0) - k_q[0]) : k_q[0])
             | (k_q[1][KW-1] ? (KW'(0) - k_q[1]) : k_q[1])
             | (k_q[2][KW-1] ? (KW'(0) - k_q[2]) : k_q[2]);
      // bit length
      idx5_q <= idx4_q;
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      deg5_q <= (orv_q == '0);
      len_q  <= len_d;
      // scale so the largest magnitude has NORM_BITS bits
      idx6_q <= idx5_q;
      neg6_q <= neg5_q;
      deg6_q <= deg5_q;
      for (int i = 0; i < 3; i++) begin
        m6_q[i] <= NORM_BITS'({mag5_q[i], {NORM_BITS{1'b0}}} >> len_q);
      end
      // squares
      idx7_q <= idx6_q;
      m7_q   <= m6_q;
      neg7_q <= neg6_q;
      deg7_q <= deg6_q;
      for (int i = 0; i < 3; i++) begin
        sq7_q[i] <= m6_q[i] * m6_q[i];
      end
      // sum of squares
      sum8_q  <= SqW'(sq7_q[0]) + SqW'(sq7_q[1]) + SqW'(sq7_q[2]);
      side8_q <= {idx7_q, m7_q, neg7_q, deg7_q};
      // rounded quotient operands: (m*2^15 + r) / (2r)
      for (int i = 0; i < 3; i++) begin
        num9_q[i] <= NumW'({mr[i], {QUO_W{1'b0}}}) + NumW'(root);
      end
      den9_q  <= {root, 1'b0};
      side9_q <= {idxr, negr, degr};
      // result
      if (vq) begin
        out_idx_q    <= sideq[SideD-1 -: IdxW];
        out_normal_q <= normal_d;
        out_deg_q    <= sideq[0];
      end
    end
  end

  assign idxr = sider[SideS-1 -: IdxW];
  assign mr   = sider[4 +: 3*NORM_BITS];
  assign negr = sider[3:1];
  assign degr = sider[0];

  tfn_isqrt #(
    .SQ_W  (SqW),
    .SIDE_W(SideS)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v8_q),
    .sq_i   (sum8_q),
    .side_i (side8_q),
    .valid_o(vr),
    .root_o (root),
    .side_o (sider)
  );

  tfn_div #(
    .NUM_W (NumW),
    .DEN_W (DenW),
    .Q_W   (QUO_W),
    .SIDE_W(SideD)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v9_q),
    .num_i  (num9_q),
    .den_i  (den9_q),
    .side_i (side9_q),
    .valid_o(vq),
    .quo_o  (quo),
    .side_o (sideq)
  );

  assign out_valid_o      = out_valid_q;
  assign out_idx_o        = out_idx_q;
  assign out_normal_o     = out_normal_q;
  assign out_degenerate_o = out_deg_q;

endmodule

/* src/triangle_face_normal.sv */
// Top level of the triangle face normal unit
//
//  channel      dir  handshake                      payload
//  s_axis       in   s_axis_tvalid_i/tready_o       tdata: indices a,b,c; coords a,b,c
//  m_axis       out  m_axis_tvalid_o/tready_i       tdata: indices, normal x,y,z; tuser
//  triangle_mode in  triangle_mode_we_i             triangle_mode_i
//
// One triangle per cycle sustained while the output is not stalled; the square root
// and divider pipes produce one result bit per stage.
// A four-entry queue in the front end feeds the arithmetic pipe, so input transfers
// continue while a result waits at the output, until the queue is full.
// The arithmetic pipe stalls as a whole while the output register holds a result that is not taken.
// Reset clears all valid bits and sets triangle_mode to 1.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
  localparam int InW  = ((3 * INDEX_WIDTH + 9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((3 * INDEX_WIDTH + 3 * NORMAL_W + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            triangle_mode_we_i,
  input  logic            triangle_mode_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // index_a, index_b, index_c, ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // out_index_a, out_index_b, out_index_c, normal_x, normal_y, normal_z
  output logic [OutW-1:0] m_axis_tdata_o,
  // degenerate
  output logic            m_axis_tuser_o
);

  localparam int ItemW = 3 * INDEX_WIDTH + 9 * COORD_WIDTH;
  localparam int IdxW  = 3 * INDEX_WIDTH;

  logic                     item_valid, pop;
  logic [ItemW-1:0]         item;
  logic [IdxW-1:0]          out_idx;
  logic [2:0][NORMAL_W-1:0] out_normal;

  tfn_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_we_i   (triangle_mode_we_i),
    .mode_i      (triangle_mode_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (s_axis_tdata_i[ItemW-1:0]),
    .pop_i       (pop),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  tfn_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_idx_o       (out_idx),
    .out_normal_o    (out_normal),
    .out_degenerate_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OutW'({out_normal[2], out_normal[1], out_normal[0], out_idx});

endmodule

/* src/tfn_checker.sv */
// Port-level checker for the triangle face normal unit, bound to the top level
`include "assert_macros.svh"

module tfn_checker import tfn_pkg::*; #(
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
  localparam int OutW = ((3 * INDEX_WIDTH + 3 * NORMAL_W + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o,
  input logic            m_axis_tuser_o
);

  localparam int NB = 3 * INDEX_WIDTH;

  logic signed [NORMAL_W-1:0] nx, ny, nz;
  logic                       any_nz, in_range;

  assign nx = m_axis_tdata_o[NB +: NORMAL_W];
  assign ny = m_axis_tdata_o[NB + NORMAL_W +: NORMAL_W];
  assign nz = m_axis_tdata_o[NB + 2 * NORMAL_W +: NORMAL_W];

  // some component is nonzero
  assign any_nz   = (nx != 0) || (ny != 0) || (nz != 0);
  // every component within one in Q1.14
  assign in_range = (nx >= -16'sd16384) && (nx <= 16'sd16384)
                 && (ny >= -16'sd16384) && (ny <= 16'sd16384)
                 && (nz >= -16'sd16384) && (nz <= 16'sd16384);

  // a stalled result stays offered
  `TFN_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  // a degenerate triangle carries a zero normal
  `TFN_ASSERT(a_deg_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> !any_nz)
  // a proper triangle has a nonzero normal
  `TFN_ASSERT(a_nondeg_nz, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o |-> any_nz)
  // every component stays within one in Q1.14
  `TFN_ASSERT(a_range, clk_i, rst_ni, m_axis_tvalid_o |-> in_range)
  // nothing is offered while reset is held
  `TFN_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind triangle_face_normal tfn_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_tfn_checker (.*);
